FILE: design/pirq_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the PIRQ link IRQ allocator.
// No dependencies; used by every design file.
package pirq_pkg;

  localparam int LinkW       = 8;
  localparam int MaskW       = 16;
  localparam int IrqW        = 4;
  localparam int MapW        = 32;
  localparam int MapSlots    = 8;
  localparam int IrqLow      = 2;
  localparam int IrqHigh     = 15;
  localparam int LinksDefault = 8;

  typedef logic [IrqW-1:0]  irq_t;
  typedef logic [LinkW-1:0] link_t;
  typedef logic [MaskW-1:0] mask_t;
  typedef logic [MapW-1:0]  map_t;

  typedef struct packed {
    logic clear;
    logic we;
    irq_t value;
  } pirq_store_cmd_t;

endpackage

FILE: design/pirq_link_irq_allocator.sv
`timescale 1ns / 1ps
// Top level of the PIRQ link IRQ allocator.
// Depends on pirq_pkg, pirq_link_store, pirq_irq_pick.
//
// Usage:
//   Input channel: drive start_of_table, link and allowed_irqs with start high.
//   A transfer happens at a rising edge with start high and busy low. busy is
//   always low, so one pin entry may be sent every cycle.
//   Result channel: done is high for exactly one cycle with irq, routed and
//   link_map valid. The receiver cannot stall; it must take the result then.
//   A result appears once the entry has passed the input register and the
//   result registers. Throughput: one entry per cycle.
//   The entry is held in an input register; lookup, IRQ choice and store
//   update happen in one combinational pass into the result registers and
//   the per-link store, so the next entry sees the updated store.
//   start_of_table set clears every link assignment before the entry.
//   Reset (rst, synchronous) clears the link store and drops pending results.
module pirq_link_irq_allocator #(
  parameter int LINKS = pirq_pkg::LinksDefault
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  output logic            busy,
  input  logic            start_of_table,
  input  pirq_pkg::link_t link,
  input  pirq_pkg::mask_t allowed_irqs,
  output logic            done,
  output pirq_pkg::irq_t  irq,
  output logic            routed,
  output pirq_pkg::map_t  link_map
);
  import pirq_pkg::*;

  localparam int SlotW = (LINKS > 1) ? $clog2(LINKS) : 1;
  localparam link_t LinkMax = LinkW'(LINKS);

  logic  in_valid;
  logic  in_start;
  link_t in_link;
  mask_t in_mask;

  irq_t [LINKS-1:0] entries;
  map_t             map_next;
  irq_t             choice;
  irq_t             cur;
  irq_t             irq_next;
  link_t            link_m1;
  logic [SlotW-1:0] slot;
  logic             link_ok;
  pirq_store_cmd_t  cmd;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      in_valid <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      in_start <= start_of_table;
      in_link  <= link;
      in_mask  <= allowed_irqs;
    end
  end

  assign link_m1 = in_link - link_t'(1);
  assign slot    = link_m1[SlotW-1:0];
  assign link_ok = (in_mask != '0) && (in_link != '0) && (in_link <= LinkMax);
  assign cur     = (in_start || !link_ok) ? irq_t'(0) : entries[slot];

  pirq_irq_pick #(.LINKS(LINKS)) u_pick (
    .entries (entries),
    .clear   (in_start),
    .mask    (in_mask),
    .choice  (choice)
  );

  always_comb begin
    if (!link_ok) begin
      irq_next = '0;
    end else if (cur != '0) begin
      irq_next = cur;
    end else begin
      irq_next = choice;
    end
    cmd.clear = in_valid && in_start;
    cmd.we    = in_valid && link_ok && (cur == '0) && (choice != '0);
    cmd.value = choice;
  end

  pirq_link_store #(.LINKS(LINKS), .SlotW(SlotW)) u_store (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .slot     (slot),
    .entries  (entries),
    .map_next (map_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid) begin
      irq      <= irq_next;
      routed   <= (irq_next != '0);
      link_map <= map_next;
    end
  end

endmodule

FILE: design/pirq_link_store.sv
`timescale 1ns / 1ps
// Per-link IRQ store: one register per link, clear and single write per cycle.
// Depends on pirq_pkg.
module pirq_link_store #(
  parameter int LINKS = pirq_pkg::LinksDefault,
  parameter int SlotW = (LINKS > 1) ? $clog2(LINKS) : 1
) (
  input  logic                             clk,
  input  logic                             rst,
  input  pirq_pkg::pirq_store_cmd_t        cmd,
  input  logic [SlotW-1:0]                 slot,
  output pirq_pkg::irq_t [LINKS-1:0]       entries,
  output pirq_pkg::map_t                   map_next
);
  import pirq_pkg::*;

  irq_t [LINKS-1:0] store;
  irq_t [LINKS-1:0] store_next;

  always_comb begin
    store_next = store;
    if (cmd.clear) begin
      store_next = '0;
    end
    if (cmd.we) begin
      store_next[slot] = cmd.value;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      store <= '0;
    end else begin
      store <= store_next;
    end
  end

  assign entries = store;

  // links above MapSlots are not shown; nibbles beyond LINKS read zero
  for (genvar k = 0; k < MapSlots; k++) begin : g_map
    if (k < LINKS) begin : g_used
      assign map_next[IrqW*k +: IrqW] = store_next[k];
    end else begin : g_unused
      assign map_next[IrqW*k +: IrqW] = '0;
    end
  end

endmodule

FILE: design/pirq_irq_pick.sv
`timescale 1ns / 1ps
// IRQ choice: lowest permitted free IRQ in 2..15, else highest permitted one.
// Depends on pirq_pkg.
module pirq_irq_pick #(
  parameter int LINKS = pirq_pkg::LinksDefault
) (
  input  pirq_pkg::irq_t [LINKS-1:0] entries,
  input  logic                       clear,
  input  pirq_pkg::mask_t            mask,
  output pirq_pkg::irq_t             choice
);
  import pirq_pkg::*;

  logic [IrqHigh:IrqLow] held;
  irq_t                  first_free;
  irq_t                  highest;

  always_comb begin
    for (int n = IrqLow; n <= IrqHigh; n++) begin
      held[n] = 1'b0;
      for (int k = 0; k < LINKS; k++) begin
        if (!clear && entries[k] == IrqW'(n)) begin
          held[n] = 1'b1;
        end
      end
    end
  end

  always_comb begin
    first_free = '0;
    for (int n = IrqHigh; n >= IrqLow; n--) begin
      if (mask[n] && !held[n]) begin
        first_free = IrqW'(n);
      end
    end
    highest = '0;
    for (int n = IrqLow; n <= IrqHigh; n++) begin
      if (mask[n]) begin
        highest = IrqW'(n);
      end
    end
    choice = (first_free != '0) ? first_free : highest;
  end

endmodule

FILE: design/pirq_checker.sv
`timescale 1ns / 1ps
// Port-level checks for the PIRQ link IRQ allocator, bound to the top level.
// Depends on pirq_pkg and pirq_link_irq_allocator.
module pirq_checker (
  input logic           clk,
  input logic           rst,
  input logic           start,
  input logic           busy,
  input logic           done,
  input pirq_pkg::irq_t irq,
  input logic           routed,
  input pirq_pkg::map_t link_map
);
  import pirq_pkg::*;

  a_accept_to_done: assert property (@(posedge clk) disable iff (rst)
    start && !busy |-> ##2 done)
    else $error("transfer without result two cycles later");

  a_done_has_source: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, 2))
    else $error("result without a matching transfer");

  a_routed_flag: assert property (@(posedge clk) disable iff (rst)
    done |-> (routed == (irq != '0)))
    else $error("routed flag disagrees with irq");

  a_irq_range: assert property (@(posedge clk) disable iff (rst)
    done && routed |-> (irq >= irq_t'(IrqLow)) && (link_map != '0))
    else $error("routed pin with IRQ below range or empty link map");

endmodule

bind pirq_link_irq_allocator pirq_checker u_pirq_checker (.*);
